// ===== sv/picr_pkg.sv =====
// Shared types, register offsets and reset values of the priority interrupt register block.
package picr_pkg;

	// Source count limits
	localparam int MAX_SOURCES     = 15;
	localparam int NUM_SOURCES_DEF = 15;

	// Stream payload widths, padded to whole bytes
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	// Item kinds carried on tuser
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_LINES = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	// Register map, byte offsets
	localparam logic [12:0] OFS_LEVEL_LAST  = 13'h00E;
	localparam logic [12:0] OFS_STAT        = 13'h200;
	localparam logic [12:0] OFS_ROM_CONTROL = 13'h204;
	localparam logic [12:0] OFS_CNT_CTRL    = 13'h205;
	localparam logic [12:0] OFS_ACK         = 13'h207;
	localparam logic [12:0] OFS_CNT         = 13'h208;

	// Source cleared by the acknowledge register and set or cleared by its level write
	localparam int ACK_SOURCE = 10;

	// Reset values
	localparam logic [7:0] ROM_CONTROL_RESET = 8'h0d;
	localparam logic [2:0] LEVEL_RESET [MAX_SOURCES] = '{
		3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd4,
		3'd2, 3'd2, 3'd0, 3'd1, 3'd3, 3'd1, 3'd7
	};

	// One input item
	typedef struct packed {
		op_t         op;
		logic [12:0] offset;
		logic [7:0]  write_data;
		logic [14:0] source_mask;
		logic        source_active;
	} item_t;

	// One result item
	typedef struct packed {
		logic [7:0]  read_data;
		logic [2:0]  highest_level;
		logic [14:0] pending_mask;
		logic        cpu_notify;
		logic        rom_write_strobe;
		logic [7:0]  rom_write_value;
	} res_t;

endpackage

// ===== sv/priority_interrupt_controller_regs.sv =====
// Priority interrupt controller register block: bus decode, pending state, level max, tick counter.
//
//  port group  dir  payload (low bit first)                                     transfer when
//  s_*         in   tuser: op; tdata: offset, write_data, source_mask,           s_tvalid & s_tready
//                   source_active
//  m_*         out  tdata: read_data, highest_level, pending_mask, cpu_notify,   m_tvalid & m_tready
//                   rom_write_strobe, rom_write_value
//
// Every item goes from the input transfer into the input register, then through decode, state update
// and the per-level pending max into the result register. One item is accepted per cycle while the
// result register is free or being taken; the throughput is set by the single read-modify-write of
// the register state. A stalled result holds its register while the input register still takes one
// more item. Reset restores the level table, ROM control 0x0d and clears the rest.
module priority_interrupt_controller_regs #(
	parameter int NUM_SOURCES = picr_pkg::NUM_SOURCES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [picr_pkg::S_TDATA_W-1:0] s_tdata,  // offset, write_data, source_mask, source_active
	input  logic [1:0]                     s_tuser,  // op
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [picr_pkg::M_TDATA_W-1:0] m_tdata   // read_data, highest_level, pending_mask,
	                                                 // cpu_notify, rom_write_strobe, rom_write_value
);
	import picr_pkg::*;

	localparam int LVL_W = $clog2(NUM_SOURCES);
	localparam logic [NUM_SOURCES-1:0] ACK_BIT = NUM_SOURCES'(1) << ACK_SOURCE;

	// Input register
	logic  valid_s1;
	item_t item_s1;
	logic  advance;

	// Result register
	logic  out_valid_q;
	res_t  res_q;

	// Register state
	logic [2:0]             levels_q [NUM_SOURCES];
	logic [NUM_SOURCES-1:0] pend_q;
	logic [7:0]             rom_q;
	logic [7:0]             cnt_ctrl_q;
	logic [63:0]            cnt_q;

	// Next state
	logic [2:0]             levels_d [NUM_SOURCES];
	logic [NUM_SOURCES-1:0] pend_d;
	logic [7:0]             rom_d;
	logic [7:0]             cnt_ctrl_d;
	logic [63:0]            cnt_d;
	res_t                   res_d;

	// Decode helpers
	logic [LVL_W-1:0]       lvl_idx;
	logic                   lvl_hit;
	logic                   stat_hit;
	logic                   cnt_hit;
	logic [31:0]            pend32;
	logic [31:0]            clr32;
	logic [NUM_SOURCES-1:0] smask;
	logic [7:0]             lvl_any;

	// Handshake: the input register moves on whenever the result register is free or its result is taken
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'({res_q.rom_write_value, res_q.rom_write_strobe,
	                              res_q.cpu_notify, res_q.pending_mask,
	                              res_q.highest_level, res_q.read_data});

	// Address decode
	assign lvl_idx  = item_s1.offset[LVL_W-1:0];
	assign lvl_hit  = (item_s1.offset <= OFS_LEVEL_LAST) && (item_s1.offset < 13'(NUM_SOURCES));
	assign stat_hit = (item_s1.offset[12:2] == OFS_STAT[12:2]);
	assign cnt_hit  = (item_s1.offset[12:3] == OFS_CNT[12:3]);
	assign pend32   = 32'(pend_q);
	assign clr32    = 32'(item_s1.write_data) << {~item_s1.offset[1:0], 3'b000};
	assign smask    = item_s1.source_mask[NUM_SOURCES-1:0];

	// Item execution
	always_comb begin
		levels_d   = levels_q;
		pend_d     = pend_q;
		rom_d      = rom_q;
		cnt_ctrl_d = cnt_ctrl_q;
		cnt_d      = cnt_q;
		res_d      = '0;
		case (item_s1.op)
			OP_READ: begin
				if (lvl_hit) begin
					res_d.read_data = 8'(levels_q[lvl_idx]);
				end else if (stat_hit) begin
					res_d.read_data = pend32[{~item_s1.offset[1:0], 3'b000} +: 8];
				end else if (item_s1.offset == OFS_ROM_CONTROL) begin
					res_d.read_data = rom_q;
				end else if (item_s1.offset == OFS_CNT_CTRL) begin
					res_d.read_data = cnt_ctrl_q;
				end else if (item_s1.offset == OFS_ACK) begin
					pend_d = pend_q & ~ACK_BIT;
				end else if (cnt_hit) begin
					res_d.read_data = cnt_q[{~item_s1.offset[2:0], 3'b000} +: 8];
				end
			end
			OP_WRITE: begin
				if (lvl_hit) begin
					levels_d[lvl_idx] = item_s1.write_data[2:0];
					if (item_s1.offset == 13'(ACK_SOURCE)) begin
						pend_d = (item_s1.write_data[2:0] != 3'd0) ? (pend_q | ACK_BIT)
						                                            : (pend_q & ~ACK_BIT);
					end else begin
						res_d.cpu_notify = 1'b1;
					end
				end else if (stat_hit) begin
					pend_d = pend_q & ~clr32[NUM_SOURCES-1:0];
				end else if (item_s1.offset == OFS_ROM_CONTROL) begin
					rom_d                  = item_s1.write_data;
					res_d.rom_write_strobe = 1'b1;
					res_d.cpu_notify       = 1'b1;
				end else if (item_s1.offset == OFS_CNT_CTRL) begin
					cnt_ctrl_d = item_s1.write_data;
				end else if (item_s1.offset == OFS_ACK) begin
					pend_d = pend_q & ~ACK_BIT;
				end
			end
			OP_LINES: begin
				pend_d = item_s1.source_active ? (pend_q | smask) : (pend_q & ~smask);
			end
			OP_TICK: begin
				if (!cnt_ctrl_q[0]) begin
					cnt_d = cnt_q + 64'd1;
				end
			end
			default: begin
				res_d = '0;
			end
		endcase

		// Any change of the pending bits notifies the CPU
		if (pend_d != pend_q) begin
			res_d.cpu_notify = 1'b1;
		end

		// Highest pending level: one OR term per level, then a short priority pick
		lvl_any = '0;
		for (int s = 0; s < NUM_SOURCES; s++) begin
			if (pend_d[s]) begin
				lvl_any[levels_d[s]] = 1'b1;
			end
		end
		for (int l = 1; l < 8; l++) begin
			if (lvl_any[l]) begin
				res_d.highest_level = 3'(l);
			end
		end

		res_d.pending_mask    = 15'(pend_d);
		res_d.rom_write_value = rom_d;
	end

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pend_q      <= '0;
			rom_q       <= ROM_CONTROL_RESET;
			cnt_ctrl_q  <= '0;
			cnt_q       <= '0;
			for (int s = 0; s < NUM_SOURCES; s++) begin
				levels_q[s] <= LEVEL_RESET[s];
			end
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				pend_q      <= pend_d;
				rom_q       <= rom_d;
				cnt_ctrl_q  <= cnt_ctrl_d;
				cnt_q       <= cnt_d;
				levels_q    <= levels_d;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op            <= op_t'(s_tuser);
			item_s1.offset        <= s_tdata[12:0];
			item_s1.write_data    <= s_tdata[20:13];
			item_s1.source_mask   <= s_tdata[35:21];
			item_s1.source_active <= s_tdata[36];
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

`ifndef NO_ASSERTIONS
	// A tick leaves the pending bits alone
	a_tick_keeps_pending: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.op == OP_TICK |=> pend_q == $past(pend_q))
		else $error("tick changed pending bits");

	// A running counter advances by one per tick
	a_tick_counts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.op == OP_TICK && !cnt_ctrl_q[0] |=> cnt_q == $past(cnt_q) + 64'd1)
		else $error("counter did not advance on tick");

	// A ROM control strobe stores the written byte and raises notify
	a_rom_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_d.rom_write_strobe |=>
			rom_q == $past(item_s1.write_data) && res_q.cpu_notify)
		else $error("ROM control write not stored or not notified");
`endif

endmodule

// ===== tb/priority_interrupt_controller_regs_tb.sv =====
// Self-checking stream testbench for the priority interrupt controller register block.
module priority_interrupt_controller_regs_tb;
	import picr_pkg::*;

	localparam int NUM_SRC       = NUM_SOURCES_DEF;
	localparam int RANDOM_ITEMS  = 280;
	localparam int IDLE_LIMIT    = 2000;
	localparam int TAIL_CYCLES   = 8;
	localparam int MAX_REPORTS   = 40;
	localparam logic [14:0] ACK_BIT = 15'(1) << ACK_SOURCE;

	// One queued bus item; hold marks a pause until all results are back
	typedef struct {
		item_t it;
		bit    hold;
	} bus_item_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;  // offset, write_data, source_mask, source_active
	logic [1:0]           s_tuser;  // op
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;  // read_data, highest_level, pending_mask,
	                                // cpu_notify, rom_write_strobe, rom_write_value

	priority_interrupt_controller_regs u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Predicted register state
	logic [2:0]  src_level [NUM_SRC];
	logic [14:0] pend_bits;
	logic [7:0]  rom_reg;
	logic [7:0]  cnt_ctrl;
	logic [63:0] tick_count;

	bus_item_t bus_items[$];
	res_t      expected_results[$];
	int        err_count;
	int        idle_cycles;
	logic      in_fire;

	// Sender burst shaping and receiver stall pattern
	int burst_left;
	int gap_left;
	int stall_mode;
	int stall_left;
	int stall_phase;

	// Apply one transfer to the predicted state and return the result it gives
	function automatic res_t predict_result(input item_t it);
		res_t        r;
		logic [14:0] nxt;
		logic [31:0] stat_word;
		logic [31:0] clr;
		int          k;
		r = '0;
		nxt = pend_bits;
		stat_word = {17'b0, pend_bits};
		case (it.op)
			OP_READ: begin
				if (it.offset <= OFS_LEVEL_LAST) begin
					if (it.offset < NUM_SRC)
						r.read_data = {5'b0, src_level[it.offset]};
				end else if (it.offset >= OFS_STAT && it.offset <= OFS_STAT + 13'd3) begin
					k = it.offset - OFS_STAT;
					r.read_data = 8'(stat_word >> ((3 - k) * 8));
				end else if (it.offset == OFS_ROM_CONTROL) begin
					r.read_data = rom_reg;
				end else if (it.offset == OFS_CNT_CTRL) begin
					r.read_data = cnt_ctrl;
				end else if (it.offset == OFS_ACK) begin
					nxt = pend_bits & ~ACK_BIT;
				end else if (it.offset >= OFS_CNT && it.offset < OFS_CNT + 13'd8) begin
					k = it.offset - OFS_CNT;
					r.read_data = 8'(tick_count >> ((7 - k) * 8));
				end
			end
			OP_WRITE: begin
				if (it.offset <= OFS_LEVEL_LAST) begin
					if (it.offset < NUM_SRC) begin
						src_level[it.offset] = it.write_data[2:0];
						// the acknowledge source follows its own level
						if (it.offset == ACK_SOURCE)
							nxt = (it.write_data[2:0] != 0) ? (pend_bits | ACK_BIT)
							                                 : (pend_bits & ~ACK_BIT);
						else
							r.cpu_notify = 1'b1;
					end
				end else if (it.offset >= OFS_STAT && it.offset <= OFS_STAT + 13'd3) begin
					// write one to clear, big-endian lanes
					k = it.offset - OFS_STAT;
					clr = {24'b0, it.write_data} << ((3 - k) * 8);
					nxt = pend_bits & ~clr[14:0];
				end else if (it.offset == OFS_ROM_CONTROL) begin
					rom_reg = it.write_data;
					r.rom_write_strobe = 1'b1;
					r.cpu_notify = 1'b1;
				end else if (it.offset == OFS_CNT_CTRL) begin
					cnt_ctrl = it.write_data;
				end else if (it.offset == OFS_ACK) begin
					nxt = pend_bits & ~ACK_BIT;
				end
			end
			OP_LINES: begin
				nxt = it.source_active ? (pend_bits | it.source_mask)
				                       : (pend_bits & ~it.source_mask);
			end
			default: begin
				if (!cnt_ctrl[0])
					tick_count = tick_count + 64'd1;
			end
		endcase
		if (nxt != pend_bits)
			r.cpu_notify = 1'b1;
		pend_bits = nxt;
		for (int s = 0; s < NUM_SRC; s++) begin
			if (pend_bits[s] && src_level[s] > r.highest_level)
				r.highest_level = src_level[s];
		end
		r.pending_mask = pend_bits;
		r.rom_write_value = rom_reg;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
	                               input logic [31:0] want);
		if (err_count < MAX_REPORTS)
			$display("mismatch %s: got 0x%0h expected 0x%0h at %0t", field, got, want, $time);
		err_count++;
	endtask

	task automatic add_item(input op_t op, input logic [12:0] ofs, input logic [7:0] data,
	                        input logic [14:0] mask, input logic act);
		bus_item_t b;
		b.it.op = op;
		b.it.offset = ofs;
		b.it.write_data = data;
		b.it.source_mask = mask;
		b.it.source_active = act;
		b.hold = 1'b0;
		bus_items.push_back(b);
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitor: predict on input transfers, check output transfers, watchdog
	always @(posedge clk) begin : monitor
		res_t want;
		res_t got;
		if (arst_n) begin
			in_fire <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				got.read_data        = m_tdata[7:0];
				got.highest_level    = m_tdata[10:8];
				got.pending_mask     = m_tdata[25:11];
				got.cpu_notify       = m_tdata[26];
				got.rom_write_strobe = m_tdata[27];
				got.rom_write_value  = m_tdata[35:28];
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
				end else begin
					want = expected_results.pop_front();
					if (got.read_data != want.read_data)
						report_mismatch("read_data", got.read_data, want.read_data);
					if (got.highest_level != want.highest_level)
						report_mismatch("highest_level", got.highest_level, want.highest_level);
					if (got.pending_mask != want.pending_mask)
						report_mismatch("pending_mask", got.pending_mask, want.pending_mask);
					if (got.cpu_notify != want.cpu_notify)
						report_mismatch("cpu_notify", got.cpu_notify, want.cpu_notify);
					if (got.rom_write_strobe != want.rom_write_strobe)
						report_mismatch("rom_write_strobe", got.rom_write_strobe,
						                want.rom_write_strobe);
					if (got.rom_write_value != want.rom_write_value)
						report_mismatch("rom_write_value", got.rom_write_value,
						                want.rom_write_value);
				end
			end
			if (s_tvalid && s_tready) begin
				item_t it;
				it.op            = op_t'(s_tuser);
				it.offset        = s_tdata[12:0];
				it.write_data    = s_tdata[20:13];
				it.source_mask   = s_tdata[35:21];
				it.source_active = s_tdata[36];
				expected_results.push_back(predict_result(it));
			end
			// count cycles without any transfer while work is outstanding
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else if (bus_items.size() != 0 || expected_results.size() != 0 || s_tvalid)
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Driver: bursts with gaps on the input, stall pattern on the output
	always @(negedge clk) begin : driver
		bus_item_t nxt;
		if (arst_n) begin
			// receiver stall pattern, with the mode redrawn when its random run ends
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(20, 80);
			end
			stall_left--;
			stall_phase++;
			case (stall_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= (stall_phase % 4 == 0);
			endcase

			// next input transfer once the current one is taken
			if (!s_tvalid || in_fire) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (bus_items.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (bus_items[0].hold && expected_results.size() != 0) begin
					s_tvalid <= 1'b0;
				end else begin
					nxt = bus_items.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= nxt.it.op;
					s_tdata  <= {3'b0, nxt.it.source_active, nxt.it.source_mask,
					             nxt.it.write_data, nxt.it.offset};
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end
				end
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int r;
		logic [12:0] ofs;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		in_fire = 1'b0;
		err_count = 0;
		idle_cycles = 0;
		burst_left = 1;
		gap_left = 0;
		stall_mode = 0;
		stall_left = 0;
		stall_phase = 0;
		for (int s = 0; s < NUM_SRC; s++)
			src_level[s] = LEVEL_RESET[s];
		pend_bits = '0;
		rom_reg = ROM_CONTROL_RESET;
		cnt_ctrl = '0;
		tick_count = '0;

		// directed: map corners, level and status behavior, counter, acknowledge
		add_item(OP_READ,  13'h000, 8'h00, 15'h0000, 1'b0);
		add_item(OP_READ,  OFS_LEVEL_LAST, 8'hff, 15'h7fff, 1'b1);
		add_item(OP_LINES, 13'h000, 8'h00, 15'h7fff, 1'b1);
		for (int k = 0; k < 4; k++)
			add_item(OP_READ, OFS_STAT + 13'(k), 8'h00, 15'h0000, 1'b0);
		add_item(OP_WRITE, OFS_STAT + 13'd3, 8'hff, 15'h0000, 1'b0);
		add_item(OP_WRITE, OFS_STAT + 13'd2, 8'hff, 15'h0000, 1'b0);
		add_item(OP_WRITE, 13'(ACK_SOURCE), 8'h05, 15'h0000, 1'b0);
		add_item(OP_WRITE, 13'(ACK_SOURCE), 8'h08, 15'h0000, 1'b0);
		add_item(OP_WRITE, OFS_LEVEL_LAST, 8'hff, 15'h0000, 1'b0);
		add_item(OP_WRITE, OFS_ROM_CONTROL, 8'ha5, 15'h0000, 1'b0);
		add_item(OP_READ,  OFS_ROM_CONTROL, 8'h00, 15'h0000, 1'b0);
		add_item(OP_WRITE, OFS_CNT_CTRL, 8'h01, 15'h0000, 1'b0);
		add_item(OP_TICK,  13'h000, 8'h00, 15'h0000, 1'b0);
		add_item(OP_WRITE, OFS_CNT_CTRL, 8'h00, 15'h0000, 1'b0);
		add_item(OP_TICK,  13'h1fff, 8'hff, 15'h7fff, 1'b1);
		add_item(OP_READ,  OFS_CNT + 13'd7, 8'h00, 15'h0000, 1'b0);
		add_item(OP_READ,  OFS_CNT, 8'h00, 15'h0000, 1'b0);
		add_item(OP_LINES, 13'h000, 8'h00, ACK_BIT, 1'b1);
		add_item(OP_READ,  OFS_ACK, 8'h00, 15'h0000, 1'b0);
		add_item(OP_LINES, 13'h000, 8'h00, 15'h7fff, 1'b0);
		add_item(OP_WRITE, 13'h206, 8'hff, 15'h0000, 1'b0);
		add_item(OP_READ,  13'h206, 8'h00, 15'h0000, 1'b0);
		add_item(OP_WRITE, 13'h1fff, 8'hff, 15'h0000, 1'b0);
		add_item(OP_READ,  13'h00f, 8'h00, 15'h0000, 1'b0);

		// random: mostly mapped offsets, some runs of ticks, some full-range noise
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				ofs = 13'($urandom_range(0, 15));
			else if (r < 85)
				ofs = OFS_STAT + 13'($urandom_range(0, 15));
			else if (r < 92)
				ofs = 13'($urandom_range(16, 'h1ff));
			else
				ofs = 13'($urandom);
			r = $urandom_range(0, 99);
			if (r < 2) begin
				// start the counter and give it a run of ticks
				add_item(OP_WRITE, OFS_CNT_CTRL, 8'(2 * $urandom_range(0, 127)),
				         15'($urandom), 1'($urandom));
				for (int t = 0; t < 40; t++)
					add_item(OP_TICK, 13'($urandom), 8'($urandom), 15'($urandom), 1'($urandom));
			end else if (r < 32) begin
				add_item(OP_READ, ofs, 8'($urandom), 15'($urandom), 1'($urandom));
			end else if (r < 62) begin
				add_item(OP_WRITE, ofs, 8'($urandom), 15'($urandom), 1'($urandom));
			end else if (r < 85) begin
				if ($urandom_range(0, 2) == 0)
					add_item(OP_LINES, ofs, 8'($urandom), 15'(1) << $urandom_range(0, 14),
					         1'($urandom));
				else
					add_item(OP_LINES, ofs, 8'($urandom), 15'($urandom), 1'($urandom));
			end else begin
				add_item(OP_TICK, ofs, 8'($urandom), 15'($urandom), 1'($urandom));
			end
			// one pause until every result is back, midway through
			if (n == RANDOM_ITEMS / 2)
				bus_items[bus_items.size() - 1].hold = 1'b1;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (bus_items.size() == 0 && !s_tvalid && expected_results.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
